[rtl/core/nonuniform_scalar_quantizer_assert.svh]
// Assertion macros for the quantizer. Both expect clk and arst_n in scope.
`ifndef NONUNIFORM_SCALAR_QUANTIZER_ASSERT_SVH
`define NONUNIFORM_SCALAR_QUANTIZER_ASSERT_SVH
`ifndef SYNTH
`define NSQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NSQ_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define NSQ_ASSERT(label, prop, msg)
`define NSQ_ASSERT_NEVER(label, cond, msg)
`endif
`endif

[rtl/core/nsq_pkg.sv]
`timescale 1ns / 1ps
package nsq_pkg;
	localparam int SAMPLE_WIDTH   = 16;
	localparam int MAX_LEVEL_BITS = 8;
	localparam int TABLE_DEPTH    = 1 << MAX_LEVEL_BITS;
	localparam int SQ_WIDTH       = 32;
	localparam int SUM_WIDTH      = 48;
	localparam int CNT_WIDTH      = 32;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_QUANT = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] REG_RANGE_MIN  = 2'd0;
	localparam logic [1:0] REG_RANGE_MAX  = 2'd1;
	localparam logic [1:0] REG_LEVEL_BITS = 2'd2;

	typedef struct packed {
		logic [1:0]                  command;
		logic [MAX_LEVEL_BITS-1:0]   level_select;
		logic [SAMPLE_WIDTH-1:0]     rep_value;
		logic [SAMPLE_WIDTH-1:0]     sample;
	} cmd_t;

	typedef struct packed {
		logic [MAX_LEVEL_BITS-1:0]   level_index;
		logic [SAMPLE_WIDTH-1:0]     quantized_value;
		logic                        out_of_range;
		logic [SQ_WIDTH-1:0]         squared_error;
		logic [SUM_WIDTH-1:0]        error_sum;
		logic [CNT_WIDTH-1:0]        sample_count;
	} result_t;

	typedef struct packed {
		logic [SAMPLE_WIDTH-1:0]     range_min;
		logic [SAMPLE_WIDTH-1:0]     range_max;
		logic [3:0]                  level_bits;
	} cfg_t;

	// Queue entry: command decoded into an operation plus the operands it needs.
	typedef struct packed {
		logic [1:0]                  op;
		logic [MAX_LEVEL_BITS-1:0]   sel;
		logic [SAMPLE_WIDTH-1:0]     value;
		logic [SAMPLE_WIDTH-1:0]     sample;
	} item_t;
endpackage

[rtl/core/nsq_ram.sv]
`timescale 1ns / 1ps
module nsq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/core/nsq_front.sv]
`timescale 1ns / 1ps
`include "nonuniform_scalar_quantizer_assert.svh"
module nsq_front import nsq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  cmd_t  cmd,
	input  logic  pop,
	output logic  item_valid,
	output item_t item
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t                 entry_q [QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;
	logic                  push;
	item_t                 decoded;

	assign busy       = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push       = start && !busy;
	assign item_valid = (count_q != '0);
	assign item       = entry_q[rd_ptr_q];

	always_comb begin
		decoded.op     = cmd.command;
		decoded.sel    = cmd.level_select;
		decoded.value  = cmd.rep_value;
		decoded.sample = cmd.sample;
		case (cmd.command)
			CMD_WRITE: decoded.sample = '0;
			CMD_QUANT: begin
				decoded.sel   = '0;
				decoded.value = '0;
			end
			default: begin
				decoded.sel    = '0;
				decoded.value  = '0;
				decoded.sample = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	`NSQ_ASSERT_NEVER(a_pop_empty, pop && !item_valid, "queue popped while empty")
	`NSQ_ASSERT(a_count_range, count_q <= (PW+1)'(QUEUE_DEPTH), "queue count overflow")
	`NSQ_ASSERT(a_full_valid, busy |-> item_valid, "queue full but reports no entry")
endmodule

[rtl/core/nsq_back.sv]
`timescale 1ns / 1ps
`include "nonuniform_scalar_quantizer_assert.svh"
module nsq_back import nsq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    pop,
	output logic    done,
	output result_t result
);
	localparam int LW = MAX_LEVEL_BITS;
	localparam int SW = SAMPLE_WIDTH;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WL   = 3'd1;
	localparam logic [2:0] ST_WR   = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_RREP = 3'd4;
	localparam logic [2:0] ST_SQ   = 3'd5;
	localparam logic [2:0] ST_ACC  = 3'd6;

	logic [2:0]             state_q;
	item_t                  item_q;
	logic [LW-1:0]          idx_q;
	logic [SW-1:0]          s_q;
	logic                   oor_q;
	logic [SW-1:0]          val_q;
	logic [SW-1:0]          diff_q;
	logic [SQ_WIDTH-1:0]    sq_q;
	logic [SUM_WIDTH-1:0]   err_q;
	logic [CNT_WIDTH-1:0]   cnt_q;
	logic [TABLE_DEPTH-1:0] written_q;
	logic                   done_q;
	result_t                res_q;

	logic                   rep_we, thr_we;
	logic [LW-1:0]          rep_raddr, thr_raddr, thr_waddr;
	logic [SW-1:0]          thr_wdata, rep_rd, thr_rd;
	logic [LW-1:0]          last_idx, idx_dn, sel_dn, sel_up;
	logic [3:0]             bits_eff;
	logic [SW-1:0]          clamped;
	logic                   clamp_oor;
	logic                   hit;
	logic [SW-1:0]          rep_val;
	logic [SW:0]            mid_sum;
	logic [SUM_WIDTH:0]     err_next_w;
	logic [SUM_WIDTH-1:0]   err_next;
	logic [CNT_WIDTH-1:0]   cnt_next;

	assign pop    = (state_q == ST_IDLE) && item_valid;
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		if (cfg.level_bits == 4'd0) begin
			bits_eff = 4'd1;
		end else if (cfg.level_bits > 4'(MAX_LEVEL_BITS)) begin
			bits_eff = 4'(MAX_LEVEL_BITS);
		end else begin
			bits_eff = cfg.level_bits;
		end
	end
	assign last_idx = LW'(({{LW{1'b0}}, 1'b1} << bits_eff) - (LW+1)'(1));

	always_comb begin
		clamped   = item.sample;
		clamp_oor = 1'b0;
		if (item.sample < cfg.range_min) begin
			clamped   = cfg.range_min;
			clamp_oor = 1'b1;
		end else if (item.sample > cfg.range_max) begin
			clamped   = cfg.range_max;
			clamp_oor = 1'b1;
		end
	end

	assign idx_dn = idx_q - LW'(1);
	assign sel_dn = item_q.sel - LW'(1);
	assign sel_up = item_q.sel + LW'(1);
	assign hit    = written_q[idx_q] && written_q[idx_dn] && (thr_rd <= s_q);
	assign rep_val = written_q[idx_q] ? rep_rd : '0;
	assign mid_sum = {1'b0, rep_rd} + {1'b0, item_q.value};

	assign err_next_w = {1'b0, err_q} + (SUM_WIDTH+1)'(sq_q);
	assign err_next   = err_next_w[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : err_next_w[SUM_WIDTH-1:0];
	assign cnt_next   = (cnt_q == {CNT_WIDTH{1'b1}}) ? cnt_q : cnt_q + CNT_WIDTH'(1);

	// Memory port control.
	always_comb begin
		rep_we    = pop && (item.op == CMD_WRITE);
		thr_we    = 1'b0;
		thr_waddr = item_q.sel;
		thr_wdata = mid_sum[SW:1];
		rep_raddr = '0;
		thr_raddr = last_idx;
		case (state_q)
			ST_IDLE: begin
				rep_raddr = (item.op == CMD_WRITE) ? item.sel - LW'(1) : last_idx;
			end
			ST_WL: begin
				thr_we    = (item_q.sel != '0) && written_q[sel_dn];
				rep_raddr = sel_up;
			end
			ST_WR: begin
				thr_we    = (item_q.sel != {LW{1'b1}}) && written_q[sel_up];
				thr_waddr = sel_up;
			end
			ST_SCAN: begin
				rep_raddr = hit ? idx_q : '0;
				thr_raddr = idx_dn;
			end
			default: begin
				rep_raddr = '0;
			end
		endcase
	end

	nsq_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_rep_ram (
		.clk   (clk),
		.we    (rep_we),
		.waddr (item.sel),
		.wdata (item.value),
		.raddr (rep_raddr),
		.rdata (rep_rd)
	);

	nsq_ram #(.WIDTH(SW), .DEPTH(TABLE_DEPTH)) u_thr_ram (
		.clk   (clk),
		.we    (thr_we),
		.waddr (thr_waddr),
		.wdata (thr_wdata),
		.raddr (thr_raddr),
		.rdata (thr_rd)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item;
			s_q    <= clamped;
			oor_q  <= clamp_oor;
		end
		if (state_q == ST_RREP) begin
			val_q  <= rep_val;
			diff_q <= (item_q.sample >= rep_val) ? item_q.sample - rep_val
			                                    : rep_val - item_q.sample;
		end
		if (state_q == ST_SQ) begin
			sq_q <= SQ_WIDTH'({{SW{1'b0}}, diff_q} * {{SW{1'b0}}, diff_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			err_q     <= '0;
			cnt_q     <= '0;
			written_q <= '0;
			done_q    <= 1'b0;
			res_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (item.op)
							CMD_WRITE: begin
								written_q[item.sel] <= 1'b1;
								state_q <= ST_WL;
							end
							CMD_QUANT: begin
								idx_q <= last_idx;
								state_q <= (clamped == cfg.range_max) ? ST_RREP : ST_SCAN;
							end
							CMD_CLEAR: begin
								err_q  <= '0;
								cnt_q  <= '0;
								done_q <= 1'b1;
								res_q  <= '0;
							end
							default: begin
								done_q <= 1'b1;
								res_q  <= '{level_index: '0, quantized_value: '0,
								          out_of_range: 1'b0, squared_error: '0,
								          error_sum: err_q, sample_count: cnt_q};
							end
						endcase
					end
				end
				ST_WL: state_q <= ST_WR;
				ST_WR: begin
					done_q  <= 1'b1;
					res_q   <= '{level_index: item_q.sel, quantized_value: item_q.value,
					           out_of_range: 1'b0, squared_error: '0,
					           error_sum: err_q, sample_count: cnt_q};
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= ST_RREP;
					end else if (idx_q == LW'(1)) begin
						idx_q   <= '0;
						state_q <= ST_RREP;
					end else begin
						idx_q <= idx_dn;
					end
				end
				ST_RREP: state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					err_q   <= err_next;
					cnt_q   <= cnt_next;
					done_q  <= 1'b1;
					res_q   <= '{level_index: idx_q, quantized_value: val_q,
					           out_of_range: oor_q, squared_error: sq_q,
					           error_sum: err_next, sample_count: cnt_next};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NSQ_ASSERT_NEVER(a_scan_zero, (state_q == ST_SCAN) && (idx_q == '0), "scan reached level zero")
	`NSQ_ASSERT(a_acc_done, (state_q == ST_ACC) |=> done, "quantize finished without a result")
	`NSQ_ASSERT(a_wr_done, (state_q == ST_WR) |=> (done && (state_q == ST_IDLE)), "write result lost")
endmodule

[rtl/core/nonuniform_scalar_quantizer.sv]
`timescale 1ns / 1ps
// Non-uniform scalar quantizer. A command is taken when start is high and busy is low;
// a two-entry queue behind the port lets up to two commands wait while the execution
// unit works. Each command yields exactly one result, shown on result for one cycle
// with done high; the receiver cannot hold it off, so it must take every transfer.
// Per command, once it leaves the queue: a level write stores the value, then updates
// the left threshold, then the right threshold; clear and no-op give their result
// straight from the idle state. A quantize reads thresholds one per cycle from the
// threshold memory, from the top level downward, until the first valid threshold not
// above the clamped sample or until level zero is reached, then reads the level value,
// squares the error and accumulates; a sample equal to the upper range bound skips the
// scan. There is no clearing pass after reset;
// which levels have been written is tracked by one flag per level.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 range_min,
// 1 range_max, 2 level_bits) in the same cycle. Write it only while the block is idle.
module nonuniform_scalar_quantizer import nsq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cmd_t                    cmd,
	output logic                    done,
	output result_t                 result,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [SAMPLE_WIDTH-1:0] cfg_data
);
	// Configuration registers.
	logic [SAMPLE_WIDTH-1:0] range_min_q;
	logic [SAMPLE_WIDTH-1:0] range_max_q;
	logic [3:0]              level_bits_q;
	cfg_t                    cfg;

	// Queue between front and back end.
	logic  item_valid;
	logic  pop;
	item_t item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q  <= '0;
			range_max_q  <= {SAMPLE_WIDTH{1'b1}};
			level_bits_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_MIN:  range_min_q  <= cfg_data;
				REG_RANGE_MAX:  range_max_q  <= cfg_data;
				REG_LEVEL_BITS: level_bits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{range_min: range_min_q, range_max: range_max_q, level_bits: level_bits_q};

	// The front end decodes each command and queues it.
	nsq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	// The back end owns both tables and the statistics, and produces the results.
	nsq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.done       (done),
		.result     (result)
	);
endmodule

[verif/tb_nonuniform_scalar_quantizer.sv]
`timescale 1ns / 1ps
module tb_nonuniform_scalar_quantizer;
	import nsq_pkg::*;

	localparam int TIMEOUT_CYCLES = 4000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	cmd_t                    cmd;
	logic                    done;
	result_t                 result;
	logic                    cfg_we;
	logic [1:0]              cfg_index;
	logic [SAMPLE_WIDTH-1:0] cfg_data;

	nonuniform_scalar_quantizer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// The clock runs with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Local copy of the quantizer state, updated as each command is queued.
	logic [15:0] mdl_rep [TABLE_DEPTH];
	bit          mdl_written [TABLE_DEPTH];
	logic [15:0] mdl_thr [TABLE_DEPTH];
	bit          mdl_thr_ok [TABLE_DEPTH];
	logic [47:0] mdl_err_sum;
	logic [31:0] mdl_count;
	logic [15:0] mdl_min;
	logic [15:0] mdl_max;
	logic [3:0]  mdl_bits;

	cmd_t    pending_cmds[$];
	result_t expected_results[$];
	int      errors;
	int      n_results;
	bit      idle_on;
	int      idle_cnt;
	int      stall_cycles;
	bit      timed_out;

	function automatic void add_cmd(cmd_t c);
		pending_cmds = {pending_cmds, c};
	endfunction

	function automatic void add_expected(result_t r);
		expected_results = {expected_results, r};
	endfunction

	function automatic void update_threshold(int i);
		if (i >= 1 && i < TABLE_DEPTH && mdl_written[i-1] && mdl_written[i]) begin
			mdl_thr[i] = 16'(({1'b0, mdl_rep[i-1]} + {1'b0, mdl_rep[i]}) >> 1);
			mdl_thr_ok[i] = 1'b1;
		end
	endfunction

	// Predict the result of one command and advance the local state.
	function automatic result_t quantize_predict(cmd_t c);
		result_t r;
		logic [15:0] s;
		int lb;
		int nlev;
		int idx;
		logic [16:0] diff;
		logic [33:0] sq;
		logic [48:0] acc;
		r = '0;
		case (c.command)
			CMD_WRITE: begin
				mdl_rep[c.level_select] = c.rep_value;
				mdl_written[c.level_select] = 1'b1;
				update_threshold(int'(c.level_select));
				update_threshold(int'(c.level_select) + 1);
				r.level_index = c.level_select;
				r.quantized_value = c.rep_value;
			end
			CMD_QUANT: begin
				s = c.sample;
				if (s < mdl_min) begin
					s = mdl_min;
					r.out_of_range = 1'b1;
				end else if (s > mdl_max) begin
					s = mdl_max;
					r.out_of_range = 1'b1;
				end
				lb = (mdl_bits < 1) ? 1 : (mdl_bits > MAX_LEVEL_BITS) ? MAX_LEVEL_BITS : mdl_bits;
				nlev = 1 << lb;
				idx = 0;
				if (s == mdl_max) idx = nlev - 1;
				else
					for (int i = 1; i < nlev; i++)
						if (mdl_thr_ok[i] && mdl_thr[i] <= s) idx = i;
				r.level_index = 8'(idx);
				r.quantized_value = mdl_written[idx] ? mdl_rep[idx] : 16'd0;
				diff = (c.sample >= r.quantized_value) ? c.sample - r.quantized_value
					: r.quantized_value - c.sample;
				sq = diff * diff;
				r.squared_error = (sq > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
				acc = mdl_err_sum + r.squared_error;
				mdl_err_sum = acc[48] ? 48'hFFFF_FFFF_FFFF : acc[47:0];
				if (mdl_count != 32'hFFFF_FFFF) mdl_count++;
			end
			CMD_CLEAR: begin
				mdl_err_sum = '0;
				mdl_count = '0;
			end
			default: ;
		endcase
		r.error_sum = mdl_err_sum;
		r.sample_count = mdl_count;
		return r;
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] op, logic [7:0] sel, logic [15:0] val,
			logic [15:0] smp);
		cmd_t c;
		c.command = op;
		c.level_select = sel;
		c.rep_value = val;
		c.sample = smp;
		return c;
	endfunction

	// Driver: offer the head of the pending queue, with random idle bursts
	// while idle_on is set. A transfer happens when start is high and busy low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			idle_cnt <= 0;
		end else begin
			if (start && !busy) begin
				add_expected(quantize_predict(cmd));
				void'(pending_cmds.pop_front());
			end
			if (start && busy) begin
				// Hold the current command until it is taken.
			end else if (idle_cnt > 0) begin
				idle_cnt <= idle_cnt - 1;
				start <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				idle_cnt <= $urandom_range(0, 7);
				start <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobed result is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				result_t e;
				e = expected_results.pop_front();
				if (result.level_index !== e.level_index) begin
					$error("level_index expected %0d actual %0d", e.level_index,
						result.level_index);
					errors++;
				end
				if (result.quantized_value !== e.quantized_value) begin
					$error("quantized_value expected %0d actual %0d", e.quantized_value,
						result.quantized_value);
					errors++;
				end
				if (result.out_of_range !== e.out_of_range) begin
					$error("out_of_range expected %0d actual %0d", e.out_of_range,
						result.out_of_range);
					errors++;
				end
				if (result.squared_error !== e.squared_error) begin
					$error("squared_error expected %0d actual %0d", e.squared_error,
						result.squared_error);
					errors++;
				end
				if (result.error_sum !== e.error_sum) begin
					$error("error_sum expected %0d actual %0d", e.error_sum, result.error_sum);
					errors++;
				end
				if (result.sample_count !== e.sample_count) begin
					$error("sample_count expected %0d actual %0d", e.sample_count,
						result.sample_count);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles in which no transfer happens on either side.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= TIMEOUT_CYCLES && !timed_out) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	// Register writes happen only while nothing is queued or in flight.
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RANGE_MIN: mdl_min = val;
			REG_RANGE_MAX: mdl_max = val;
			default: mdl_bits = val[3:0];
		endcase
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_results.size() != 0 || start)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write a sorted table covering the levels in use so that every level
	// chosen by a later quantize has a stored value.
	task automatic load_table(int nlev);
		logic [15:0] v;
		v = 16'($urandom_range(0, 200));
		for (int i = 0; i < nlev; i++) begin
			add_cmd(make_cmd(CMD_WRITE, 8'(i), v, 16'($urandom)));
			v = 16'(v + $urandom_range(0, 65535 / nlev));
		end
	endtask

	function automatic cmd_t random_item(logic [15:0] lo, logic [15:0] hi, int nlev);
		int k;
		k = $urandom_range(0, 19);
		if (k < 14) return make_cmd(CMD_QUANT, 8'($urandom), 16'($urandom),
			(k < 9) ? 16'($urandom_range(lo, hi)) : 16'($urandom));
		if (k < 17) return make_cmd(CMD_WRITE, 8'($urandom_range(0, nlev - 1)),
			16'($urandom), 16'($urandom));
		if (k < 18) return make_cmd(CMD_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
		return make_cmd(CMD_NOP, 8'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	initial begin
		logic [15:0] lo;
		logic [15:0] hi;
		logic [3:0]  lb;
		int nlev;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b0;
		mdl_min = 16'd0;
		mdl_max = 16'hFFFF;
		mdl_bits = 4'd8;
		mdl_err_sum = '0;
		mdl_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			mdl_written[i] = 1'b0;
			mdl_thr_ok[i] = 1'b0;
			mdl_rep[i] = '0;
			mdl_thr[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: two levels at the value extremes, quantizing the range
		// bounds, out-of-range samples on both sides, a write beyond the levels
		// in use, clear and no-op.
		write_reg(REG_RANGE_MIN, 16'd100);
		write_reg(REG_RANGE_MAX, 16'd65000);
		write_reg(REG_LEVEL_BITS, 16'd1);
		add_cmd(make_cmd(CMD_WRITE, 8'd0, 16'd0, 16'd0));
		add_cmd(make_cmd(CMD_WRITE, 8'd1, 16'hFFFF, 16'hFFFF));
		add_cmd(make_cmd(CMD_WRITE, 8'd255, 16'hFFFF, 16'd0));
		add_cmd(make_cmd(CMD_QUANT, 8'hFF, 16'hFFFF, 16'd0));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'hFFFF));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd100));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd65000));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd32767));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd32768));
		add_cmd(make_cmd(CMD_NOP, 8'hFF, 16'hFFFF, 16'hFFFF));
		add_cmd(make_cmd(CMD_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd1));
		wait_drained();
		// Zero level bits counts as one; fifteen counts as the maximum.
		write_reg(REG_LEVEL_BITS, 16'd0);
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd40000));
		wait_drained();
		write_reg(REG_RANGE_MIN, 16'd0);
		write_reg(REG_RANGE_MAX, 16'hFFFF);
		write_reg(REG_LEVEL_BITS, 16'd15);
		load_table(TABLE_DEPTH);
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'hFFFF));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd0));
		add_cmd(make_cmd(CMD_QUANT, 8'd0, 16'd0, 16'd30000));
		wait_drained();

		// Random phases with different range and level settings; the last
		// phase runs without idle bursts.
		for (int ph = 0; ph < 8; ph++) begin
			idle_on = (ph < 7);
			lb = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd1 : 4'($urandom_range(1, 5));
			lo = (ph == 2) ? 16'd0 : 16'($urandom_range(0, 20000));
			hi = (ph == 2) ? 16'hFFFF : 16'($urandom_range(40000, 65535));
			nlev = 1 << lb;
			write_reg(REG_RANGE_MIN, lo);
			write_reg(REG_RANGE_MAX, hi);
			write_reg(REG_LEVEL_BITS, 16'(lb));
			load_table(nlev);
			for (int n = 0; n < 150; n++) add_cmd(random_item(lo, hi, nlev));
			wait_drained();
		end

		$display("Covered %0d results over directed cases and eight random phases", n_results);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/nsq_pkg.sv
rtl/core/nsq_ram.sv
rtl/core/nsq_front.sv
rtl/core/nsq_back.sv
rtl/core/nonuniform_scalar_quantizer.sv
verif/tb_nonuniform_scalar_quantizer.sv
